// ===== hw/rtl/fsta_pkg.sv =====
// ----------------------------------------------------------------------------
// fsta_pkg
// Shared types and constants of the flow session table with aging.
// ----------------------------------------------------------------------------
package fsta_pkg;

    localparam int MODE_W  = 2;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int SLOT_W  = 11;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;
    localparam int EXP_W   = 12;
    localparam int TOUT_W  = 16;

    localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 16'd600;

    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] RES_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] RES_NEW      = 3'd1;
    localparam logic [STAT_W-1:0] RES_EVICT    = 3'd2;
    localparam logic [STAT_W-1:0] RES_NO_SLOT  = 3'd3;
    localparam logic [STAT_W-1:0] RES_REFRESH  = 3'd4;
    localparam logic [STAT_W-1:0] RES_RELEASE  = 3'd5;
    localparam logic [STAT_W-1:0] RES_UNUSED   = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_SLOT_RD,
        S_SLOT_ACT,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic alloc;
        logic slot_rd;
        logic slot_act;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/fsta_if.sv =====
// ----------------------------------------------------------------------------
// fsta_in_if / fsta_out_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface fsta_in_if;
    import fsta_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IP_W-1:0]   client_ip;
    logic [PORT_W-1:0] client_port;
    logic [SLOT_W-1:0] slot_index;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, mode, client_ip, client_port, slot_index, now_seconds,
                    input ready);
    modport sink   (input valid, mode, client_ip, client_port, slot_index, now_seconds,
                    output ready);
endinterface

interface fsta_out_if;
    import fsta_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [EXP_W-1:0]  expired_count;

    modport source (output valid, status, slot, expired_count, input ready);
    modport sink   (input valid, status, slot, expired_count, output ready);
endinterface

// ===== hw/rtl/fsta_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsta_ctrl
// Sequencer for clearing, lookup scans, allocation and slot operations.
// ----------------------------------------------------------------------------
module fsta_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_lookup,
    output logic            in_ready,
    input  fsta_pkg::stat_t stat,
    output fsta_pkg::cmd_t  cmd
);
    import fsta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_lookup ? S_SCAN : S_SLOT_RD;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = S_DONE;
                end
                else if (stat.scan_end)
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:    state_next = S_DONE;
            S_SLOT_RD:  state_next = S_SLOT_ACT;
            S_SLOT_ACT: state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:    cmd.clear = 1'b1;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:     cmd.scan = 1'b1;
            S_ALLOC:    cmd.alloc = 1'b1;
            S_SLOT_RD:  cmd.slot_rd = 1'b1;
            S_SLOT_ACT: cmd.slot_act = 1'b1;
            S_DONE:     cmd.out_load = stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/fsta_dp.sv =====
// ----------------------------------------------------------------------------
// fsta_dp
// Table memories, scan pipeline, age trackers and result registers.
// ----------------------------------------------------------------------------
module fsta_dp
#(
    parameter int TABLE_ENTRIES = 2048
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fsta_pkg::TOUT_W-1:0]   cfg_wdata,
    input  logic [fsta_pkg::MODE_W-1:0]   in_mode,
    input  logic [fsta_pkg::IP_W-1:0]     in_ip,
    input  logic [fsta_pkg::PORT_W-1:0]   in_port,
    input  logic [fsta_pkg::SLOT_W-1:0]   in_sidx,
    input  logic [fsta_pkg::TIME_W-1:0]   in_now,
    input  fsta_pkg::cmd_t                cmd,
    output fsta_pkg::stat_t               stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [fsta_pkg::STAT_W-1:0]   out_status,
    output logic [fsta_pkg::SLOT_W-1:0]   out_slot,
    output logic [fsta_pkg::EXP_W-1:0]    out_expired
);
    import fsta_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEY_W = IP_W + PORT_W;
    localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // Memories.
    logic              vmem [TABLE_ENTRIES];
    logic [KEY_W-1:0]  kmem [TABLE_ENTRIES];
    logic [TIME_W-1:0] tmem [TABLE_ENTRIES];

    logic              vq_reg;
    logic [KEY_W-1:0]  kq_reg;
    logic [TIME_W-1:0] tq_reg;

    // Request and configuration.
    logic [TOUT_W-1:0] tout_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] sidx_reg;
    logic [TIME_W-1:0] now_reg;

    // Scan state.
    logic [IDX_W:0]    cnt_reg;
    logic              proc_v_reg;
    logic [IDX_W-1:0]  proc_addr_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [TIME_W-1:0] best_reg;
    logic              have_old_reg;
    logic [IDX_W-1:0]  old_reg;
    logic              have_free_reg;
    logic [IDX_W-1:0]  free_reg;

    // Result and output.
    logic [STAT_W-1:0] res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [EXP_W-1:0]  res_exp_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [EXP_W-1:0]  out_exp_reg;

    logic              issue_v;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  sidx_addr;
    logic              sidx_ok;
    logic              proc_act;
    logic              match;
    logic [TIME_W-1:0] age;
    logic              expire;
    logic              hit;

    logic              vwe;
    logic [IDX_W-1:0]  vwa;
    logic              vwd;
    logic              kwe;
    logic [IDX_W-1:0]  kwa;
    logic              twe;
    logic [IDX_W-1:0]  twa;
    logic [IDX_W-1:0]  alloc_addr;

    assign sidx_addr = IDX_W'(sidx_reg);
    assign sidx_ok   = 32'(sidx_reg) < 32'(TABLE_ENTRIES);
    assign issue_v   = cmd.scan && (cnt_reg < CNT_END);
    assign rd_addr   = cmd.slot_rd ? sidx_addr : cnt_reg[IDX_W-1:0];
    assign rd_en     = issue_v || cmd.slot_rd;

    assign proc_act  = cmd.scan && proc_v_reg;
    assign match     = vq_reg && (kq_reg == key_reg);
    assign age       = now_reg - tq_reg;
    assign expire    = vq_reg && !match && (age > TIME_W'(tout_reg));
    assign hit       = proc_act && match;
    assign alloc_addr = have_free_reg ? free_reg : old_reg;

    assign stat.clear_last = cnt_reg == (IDX_W+1)'(TABLE_ENTRIES - 1);
    assign stat.scan_hit   = hit;
    assign stat.scan_end   = proc_act && !match && (proc_addr_reg == IDX_LAST);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Write port selection; the commands are active one at a time.
    always_comb
    begin
        vwe = 1'b0;
        vwa = cnt_reg[IDX_W-1:0];
        vwd = 1'b0;
        kwe = 1'b0;
        kwa = alloc_addr;
        twe = 1'b0;
        twa = proc_addr_reg;
        if (cmd.clear)
        begin
            vwe = 1'b1;
        end
        else if (proc_act)
        begin
            vwe = expire;
            vwa = proc_addr_reg;
            twe = match;
        end
        else if (cmd.alloc && (have_free_reg || have_old_reg))
        begin
            vwe = 1'b1;
            vwa = alloc_addr;
            vwd = 1'b1;
            kwe = 1'b1;
            twe = 1'b1;
            twa = alloc_addr;
        end
        else if (cmd.slot_act && sidx_ok && vq_reg)
        begin
            vwe = mode_reg == MODE_RELEASE;
            vwa = sidx_addr;
            twe = mode_reg == MODE_REFRESH;
            twa = sidx_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vwa] <= vwd;
        end
        if (kwe)
        begin
            kmem[kwa] <= key_reg;
        end
        if (twe)
        begin
            tmem[twa] <= now_reg;
        end
        if (rd_en)
        begin
            vq_reg <= vmem[rd_addr];
            kq_reg <= kmem[rd_addr];
            tq_reg <= tmem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tout_reg      <= TIMEOUT_RESET;
            cnt_reg       <= '0;
            proc_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tout_reg <= cfg_wdata;
            end
            if (cmd.clear || issue_v)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            proc_v_reg <= issue_v;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan trackers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= in_mode;
            key_reg       <= {in_ip, in_port};
            sidx_reg      <= in_sidx;
            now_reg       <= in_now;
            exp_reg       <= '0;
            best_reg      <= '0;
            have_old_reg  <= 1'b0;
            old_reg       <= '0;
            have_free_reg <= 1'b0;
            free_reg      <= '0;
        end
        if (issue_v)
        begin
            proc_addr_reg <= cnt_reg[IDX_W-1:0];
        end
        if (proc_act && !match)
        begin
            if (expire)
            begin
                exp_reg <= exp_reg + 1'b1;
            end
            else if (vq_reg && (age > best_reg))
            begin
                best_reg     <= age;
                old_reg      <= proc_addr_reg;
                have_old_reg <= 1'b1;
            end
            if ((!vq_reg || expire) && !have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_reg      <= proc_addr_reg;
            end
        end
        if (hit)
        begin
            res_status_reg <= RES_HIT;
            res_slot_reg   <= SLOT_W'(proc_addr_reg);
            res_exp_reg    <= exp_reg;
        end
        if (cmd.alloc)
        begin
            res_exp_reg <= exp_reg;
            if (have_free_reg)
            begin
                res_status_reg <= RES_NEW;
                res_slot_reg   <= SLOT_W'(free_reg);
            end
            else if (have_old_reg)
            begin
                res_status_reg <= RES_EVICT;
                res_slot_reg   <= SLOT_W'(old_reg);
            end
            else
            begin
                res_status_reg <= RES_NO_SLOT;
                res_slot_reg   <= '0;
            end
        end
        if (cmd.slot_act)
        begin
            res_slot_reg <= sidx_reg;
            res_exp_reg  <= '0;
            if (sidx_ok && vq_reg && (mode_reg == MODE_REFRESH))
            begin
                res_status_reg <= RES_REFRESH;
            end
            else if (sidx_ok && vq_reg && (mode_reg == MODE_RELEASE))
            begin
                res_status_reg <= RES_RELEASE;
            end
            else
            begin
                res_status_reg <= RES_UNUSED;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_exp_reg    <= res_exp_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_expired = out_exp_reg;

endmodule

// ===== hw/rtl/flow_session_table_aging.sv =====
// ----------------------------------------------------------------------------
// flow_session_table_aging
// Session table keyed by client IPv4 address and port, with idle aging and
// eviction of the oldest entry when the table is full.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake       Beat contents
//   in_ch     sink        valid/ready     mode, client_ip, client_port,
//                                         slot_index, now_seconds
//   out_ch    source      valid/ready     status, slot, expired_count
//   cfg       write only  cfg_we          idle_timeout (cfg_wdata)
//
// A lookup reads one table entry per cycle from the single read port of the
// table memories, so a miss scans every entry and a hit ends the scan early.
// Refresh, release and unknown modes read the addressed slot, then act on it.
// After reset a clearing pass marks every slot free; no request beat is taken
// during it, while configuration writes are. A finished result waits in the
// output register; the next request beat is taken while it waits, and the
// block stalls only if a second result is ready before the first has been
// taken.
//
module flow_session_table_aging
#(
    parameter int TABLE_ENTRIES = 2048
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsta_pkg::TOUT_W-1:0] cfg_wdata,
    fsta_in_if.sink                     in_ch,
    fsta_out_if.source                  out_ch
);
    import fsta_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences the clearing pass, scans and slot operations.
    fsta_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_lookup (in_ch.mode == MODE_LOOKUP),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the table, the scan trackers and the output register.
    fsta_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_mode     (in_ch.mode),
        .in_ip       (in_ch.client_ip),
        .in_port     (in_ch.client_port),
        .in_sidx     (in_ch.slot_index),
        .in_now      (in_ch.now_seconds),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_status  (out_ch.status),
        .out_slot    (out_ch.slot),
        .out_expired (out_ch.expired_count)
    );

    // One request is worked on at a time: no beat right after an accepted one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request accepted while the previous one is in progress");

    // A scan cannot both hit and run off the end of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.scan_hit && stat.scan_end))
        else $error("scan reported hit and end together");

    // A failed lookup reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == RES_NO_SLOT)) |-> (out_ch.slot == '0))
        else $error("no-slot result with nonzero slot");

    // Only lookups free expired sessions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == RES_REFRESH || out_ch.status == RES_RELEASE
                          || out_ch.status == RES_UNUSED)) |-> (out_ch.expired_count == '0))
        else $error("slot operation reported expired sessions");

endmodule

// ===== dv/fsta_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsta testbench channel note
// The channel interfaces come from the RTL; this file only holds shared
// testbench constants used by the checker and the top.
// ----------------------------------------------------------------------------
package fsta_tb_pkg;
    localparam int TB_ENTRIES = 2048;
    localparam logic [1:0] MODE_NONE = 2'd3;
endpackage

// ===== dv/fsta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsta_checker
// Watches the request and result channels, predicts each result of the
// session table and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module fsta_checker
    import fsta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [TOUT_W-1:0]   cfg_wdata,
    fsta_in_if                  in_ch,
    fsta_out_if                 out_ch,
    output int                  fail_count,
    output int                  pending
);
    localparam int N = fsta_tb_pkg::TB_ENTRIES;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [EXP_W-1:0]  expired;
    } session_result_t;

    logic              sess_valid [N];
    logic [IP_W-1:0]   sess_ip    [N];
    logic [PORT_W-1:0] sess_port  [N];
    logic [TIME_W-1:0] sess_seen  [N];
    logic [TOUT_W-1:0] timeout;
    session_result_t   awaited_results [$];

    function automatic session_result_t table_access(logic [MODE_W-1:0] mode,
        logic [IP_W-1:0] ip, logic [PORT_W-1:0] port, logic [SLOT_W-1:0] sidx,
        logic [TIME_W-1:0] now);
        session_result_t r;
        logic [TIME_W-1:0] age, best_age;
        logic [EXP_W-1:0] expired;
        int oldest;
        bit have_oldest;
        r = '0;
        expired = '0;
        best_age = '0;
        oldest = 0;
        have_oldest = 0;
        if (mode == MODE_LOOKUP) begin
            for (int i = 0; i < N; i++) begin
                if (!sess_valid[i])
                    continue;
                if (sess_ip[i] == ip && sess_port[i] == port) begin
                    sess_seen[i] = now;
                    r = '{RES_HIT, SLOT_W'(i), expired};
                    return r;
                end
                age = now - sess_seen[i];
                if (age > {16'd0, timeout}) begin
                    sess_valid[i] = 1'b0;
                    expired++;
                end else if (age > best_age) begin
                    best_age = age;
                    oldest = i;
                    have_oldest = 1;
                end
            end
            for (int i = 0; i < N; i++) begin
                if (!sess_valid[i]) begin
                    sess_valid[i] = 1'b1;
                    sess_ip[i] = ip;
                    sess_port[i] = port;
                    sess_seen[i] = now;
                    r = '{RES_NEW, SLOT_W'(i), expired};
                    return r;
                end
            end
            if (have_oldest) begin
                sess_ip[oldest] = ip;
                sess_port[oldest] = port;
                sess_seen[oldest] = now;
                r = '{RES_EVICT, SLOT_W'(oldest), expired};
                return r;
            end
            r = '{RES_NO_SLOT, '0, expired};
            return r;
        end
        if ((mode == MODE_REFRESH || mode == MODE_RELEASE) && sess_valid[sidx]) begin
            if (mode == MODE_REFRESH) begin
                sess_seen[sidx] = now;
                r = '{RES_REFRESH, sidx, '0};
            end else begin
                sess_valid[sidx] = 1'b0;
                r = '{RES_RELEASE, sidx, '0};
            end
            return r;
        end
        r = '{RES_UNUSED, sidx, '0};
        return r;
    endfunction

    assign pending = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        session_result_t want, got;
        if (!rst_n)
        begin
            timeout <= TIMEOUT_RESET;
            fail_count <= 0;
            awaited_results.delete();
            for (int i = 0; i < N; i++)
                sess_valid[i] = 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout <= cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(table_access(in_ch.mode, in_ch.client_ip,
                    in_ch.client_port, in_ch.slot_index, in_ch.now_seconds));
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.status, out_ch.slot, out_ch.expired_count};
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want != got)
                    begin
                        $display("%0t: mismatch status/slot/expired expected %0d/%0d/%0d actual %0d/%0d/%0d",
                            $time, want.status, want.slot, want.expired,
                            got.status, got.slot, got.expired);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_flow_session_table_aging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_session_table_aging
// Drives lookups, refreshes and releases into the session table under three
// flow-control phases and several timeout settings; the checker predicts
// every result beat and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_flow_session_table_aging;
    import fsta_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [TOUT_W-1:0] cfg_wdata = '0;
    int fail_count, pending;
    longint cycles = 0;
    int src_idle, snk_idle;

    // A small pool of keys makes hits and refreshes of known slots frequent.
    logic [IP_W-1:0]   key_ip   [8];
    logic [PORT_W-1:0] key_port [8];
    logic [TIME_W-1:0] clock_s;

    fsta_in_if  in_ch ();
    fsta_out_if out_ch ();

    flow_session_table_aging dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    fsta_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The generous limit covers the clearing pass plus about 200 full scans
    // with every stall, taken many times over.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 6000000)
        begin
            $display("flow_session_table_aging verification failed");
            $finish;
        end
    end

    // The result side stalls at its own random rate, drawn fresh each cycle.
    initial out_ch.ready = 1'b0;
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= snk_idle);

    // Sends one request beat; a random gap may come first. Valid stays high
    // after the beat is taken until the next gap, beat or idle stretch.
    task automatic send_beat(logic [MODE_W-1:0] mode, logic [IP_W-1:0] ip,
        logic [PORT_W-1:0] port, logic [SLOT_W-1:0] sidx, logic [TIME_W-1:0] now);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.client_ip <= ip;
        in_ch.client_port <= port;
        in_ch.slot_index <= sidx;
        in_ch.now_seconds <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Registers change only with nothing in flight; the extra wait covers a
    // result still being built after the last expected beat arrived.
    task automatic write_timeout(logic [TOUT_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random beat: mostly lookups over the key pool with time moving on,
    // plus refreshes and releases of low slots, random keys and mode three.
    task automatic random_beat();
        int k, pick;
        k = $urandom_range(7);
        pick = $urandom_range(99);
        clock_s = clock_s + TIME_W'($urandom_range(40));
        if (pick < 55)
            send_beat(MODE_LOOKUP, key_ip[k], key_port[k], SLOT_W'($urandom), clock_s);
        else if (pick < 65)
            send_beat(MODE_LOOKUP, $urandom, PORT_W'($urandom), SLOT_W'($urandom),
                $urandom);
        else if (pick < 80)
            send_beat(MODE_REFRESH, $urandom, PORT_W'($urandom),
                SLOT_W'($urandom_range(12)), clock_s);
        else if (pick < 93)
            send_beat(MODE_RELEASE, $urandom, PORT_W'($urandom),
                SLOT_W'($urandom_range(12)), clock_s);
        else
            send_beat(fsta_tb_pkg::MODE_NONE, $urandom, PORT_W'($urandom),
                SLOT_W'($urandom), $urandom);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.client_ip = '0;
        in_ch.client_port = '0;
        in_ch.slot_index = '0;
        in_ch.now_seconds = '0;
        src_idle = 34;
        snk_idle = 69;
        clock_s = 32'hFFFF_FF00;
        for (int i = 0; i < 8; i++)
        begin
            key_ip[i] = $urandom;
            key_port[i] = PORT_W'($urandom);
        end
        key_ip[0] = '1;
        key_port[0] = '1;
        key_ip[1] = '0;
        key_port[1] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: new slots at extreme keys, hit, refresh, release, unused
        // slots, mode three, and the top slot index.
        send_beat(MODE_LOOKUP, key_ip[0], key_port[0], '1, clock_s);
        send_beat(MODE_LOOKUP, key_ip[1], key_port[1], '0, clock_s + 5);
        send_beat(MODE_LOOKUP, key_ip[0], key_port[0], '0, clock_s + 10);
        send_beat(MODE_REFRESH, '0, '0, 11'd1, clock_s + 20);
        send_beat(MODE_REFRESH, '0, '0, 11'd2047, clock_s + 20);
        send_beat(MODE_RELEASE, '1, '1, 11'd2047, clock_s);
        send_beat(MODE_RELEASE, '0, '0, 11'd1, clock_s + 30);
        send_beat(MODE_RELEASE, '0, '0, 11'd1, clock_s + 30);
        send_beat(fsta_tb_pkg::MODE_NONE, '1, '1, '1, '1);
        // Time wraps past zero; slot 0 ages beyond the timeout and expires.
        clock_s = clock_s + 700;
        send_beat(MODE_LOOKUP, key_ip[2], key_port[2], '0, clock_s);
        // Future timestamp: an entry stamped ahead of now also expires.
        send_beat(MODE_LOOKUP, key_ip[3], key_port[3], '0, clock_s + 5000);
        send_beat(MODE_LOOKUP, key_ip[4], key_port[4], '0, clock_s);

        // Timeout zero: every entry older than now goes on each scan.
        write_timeout(16'd0);
        send_beat(MODE_LOOKUP, key_ip[5], key_port[5], '0, clock_s);
        send_beat(MODE_LOOKUP, key_ip[6], key_port[6], '0, clock_s + 1);
        send_beat(MODE_LOOKUP, key_ip[6], key_port[6], '0, clock_s + 1);
        write_timeout(16'hFFFF);
        send_beat(MODE_LOOKUP, key_ip[7], key_port[7], '0, clock_s + 3);
        send_beat(MODE_LOOKUP, key_ip[5], key_port[5], '0, clock_s + 70000);
        write_timeout(16'd60);

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int n = 0; n < 47; n++)
                random_beat();
            if (ph == 0)
            begin
                src_idle = 69;
                snk_idle = 34;
                write_timeout(16'd300);
            end
            else if (ph == 1)
            begin
                src_idle = 0;
                snk_idle = 0;
                write_timeout(16'd15);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        if (fail_count == 0)
            $display("flow_session_table_aging verification clean");
        else
            $display("flow_session_table_aging verification failed");
        $finish;
    end
endmodule
